// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shorthand for clocked implication checks on clk_i with rst_ni as disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MLFQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mlfq check failed");

// next-cycle implication
`define MLFQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mlfq check failed");

`endif

// ===== design/mlfq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfq_pkg
// sizes, result codes and shared types of the feedback queue scheduler
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int unsigned NUM_LEVELS = 4;
  localparam int unsigned NUM_TASKS  = 16;

  localparam int unsigned LVL_W      = $clog2(NUM_LEVELS);
  localparam int unsigned TASK_AW    = $clog2(NUM_TASKS);
  localparam int unsigned CNT_W      = $clog2(NUM_TASKS + 1);
  localparam int unsigned FIFO_DEPTH = NUM_LEVELS * NUM_TASKS;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // word field widths
  localparam int unsigned ID_W       = 4;
  localparam int unsigned REM_W      = 16;
  localparam int unsigned BP_W       = 8;
  localparam int unsigned OUTCOME_W  = 3;
  localparam int unsigned OLVL_W     = 2;
  localparam int unsigned USED_W     = 4;
  localparam int unsigned ELAPSED_W  = 32;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_PAD_W   = IN_DATA_W - (ID_W + REM_W + BP_W);
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - (ID_W + OLVL_W + USED_W + REM_W + ELAPSED_W);

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_ADMITTED = 3'd0,
    OUT_REJECTED = 3'd1,
    OUT_IDLE     = 3'd2,
    OUT_FINISHED = 3'd3,
    OUT_BLOCKED  = 3'd4,
    OUT_DEMOTED  = 3'd5,
    OUT_REQUEUED = 3'd6
  } outcome_e;

  // verdict of one scheduling round
  typedef struct packed {
    outcome_e               outcome;
    logic [REM_W-1:0]       used;
    logic [REM_W-1:0]       left;
  } round_t;

  // flat queue store address of a slot in a level
  function automatic logic [FIFO_AW-1:0] fifo_addr(input logic [LVL_W-1:0] lvl,
                                                   input logic [TASK_AW-1:0] pos);
    fifo_addr = FIFO_AW'(lvl) * FIFO_AW'(NUM_TASKS) + FIFO_AW'(pos);
  endfunction

endpackage

// ===== design/multilevel_feedback_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// per-level task fifos in ram, remaining-time table in ram, one round per word
// ----------------------------------------------------------------------------
// Each input word is either an admit (tuser 0) or a scheduling round (tuser 1),
// and each produces exactly one output word. An admit is accepted, then the
// duplicate check and the writes to the level 0 queue and remaining-time
// table follow. A round is accepted (pick the lowest non-empty level and
// read its head slot from the queue ram), reads the task's remaining time from
// the table ram, then evaluates the quantum and writes back. A round with every
// level empty skips both ram reads and goes straight to the output word. The
// final state waits while the output register holds a word not yet taken;
// the next input word is accepted in the cycle after a word completes. No
// clearing pass follows reset: queue slots and table entries are only read
// after they were written.
module multilevel_feedback_queue_scheduler import mlfq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input words
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // task_id [3:0], burst_length [19:4], block_point [27:20], zero [31:28]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // action [0]
  input  logic                  s_axis_tuser_i,
  // result words
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // served_id [3:0], served_level [5:4], ticks_used [9:6], ticks_left [25:10],
  // elapsed [57:26], zero [63:58]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // outcome [2:0]
  output logic [OUTCOME_W-1:0]  m_axis_tuser_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,   // waiting for a word
    ST_ADM  = 4'b0010,   // admit commit
    ST_HEAD = 4'b0100,   // head id back, table read issued
    ST_EXEC = 4'b1000    // quantum evaluation and write back
  } state_e;

  state_e               state_q, state_d;

  // captured input word
  logic [ID_W-1:0]      id_q;
  logic [REM_W-1:0]     burst_q;
  logic [BP_W-1:0]      bp_q;
  logic                 empty_q;     // round found every level empty
  logic [LVL_W-1:0]     lvl_q;       // level the head was taken from

  // queue bookkeeping, one head and fill count per level
  logic [TASK_AW-1:0]   heads_q  [NUM_LEVELS];
  logic [CNT_W-1:0]     counts_q [NUM_LEVELS];
  logic [NUM_TASKS-1:0] present_q;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  outcome_e             out_user_q, out_user_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic                 s_hs;
  logic                 out_free;
  logic                 any_busy;
  logic [LVL_W-1:0]     enc_lvl;
  logic [LVL_W-1:0]     push_lvl;
  logic [LVL_W-1:0]     sel_lvl;
  logic [TASK_AW-1:0]   sel_head;
  logic [CNT_W-1:0]     sel_cnt;
  logic [CNT_W:0]       tail_sum;
  logic [TASK_AW-1:0]   tail_pos;
  logic [TASK_AW-1:0]   head_next;
  logic                 run_pop;
  logic                 adm_fire;
  logic                 exec_fire;
  logic                 adm_ok;
  logic                 push_en;
  logic                 run_done;
  logic                 task_drop;
  logic [TASK_AW-1:0]   adm_idx;
  logic [TASK_AW-1:0]   run_idx;

  logic                 fifo_we;
  logic [FIFO_AW-1:0]   fifo_waddr;
  logic [ID_W-1:0]      fifo_wdata;
  logic [FIFO_AW-1:0]   fifo_raddr;
  logic [ID_W-1:0]      fifo_rdata;

  logic                 rem_we;
  logic                 rem_re;
  logic [TASK_AW-1:0]   rem_waddr;
  logic [REM_W-1:0]     rem_wdata;
  logic [REM_W-1:0]     rem_rdata;

  round_t               round;

  // handshakes
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_hs            = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // lowest non-empty level
  always_comb begin
    enc_lvl  = '0;
    any_busy = 1'b0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (counts_q[l] != '0) begin
        enc_lvl  = LVL_W'(l);
        any_busy = 1'b1;
      end
    end
  end

  // demote one level, the last level requeues in place
  assign push_lvl = (lvl_q == LVL_W'(NUM_LEVELS - 1)) ? lvl_q : lvl_q + 1'b1;

  // one level is looked at per cycle: pop on accept, push on commit
  always_comb begin
    case (state_q)
      ST_ADM:  sel_lvl = '0;
      ST_EXEC: sel_lvl = push_lvl;
      default: sel_lvl = enc_lvl;
    endcase
  end

  assign sel_head  = heads_q[sel_lvl];
  assign sel_cnt   = counts_q[sel_lvl];
  assign tail_sum  = (CNT_W + 1)'(sel_head) + (CNT_W + 1)'(sel_cnt);
  assign tail_pos  = (tail_sum >= (CNT_W + 1)'(NUM_TASKS))
                   ? TASK_AW'(tail_sum - (CNT_W + 1)'(NUM_TASKS))
                   : TASK_AW'(tail_sum);
  assign head_next = (sel_head == TASK_AW'(NUM_TASKS - 1)) ? '0 : sel_head + 1'b1;

  // events
  assign run_pop   = s_hs && s_axis_tuser_i && any_busy;
  assign adm_fire  = (state_q == ST_ADM) && out_free;
  assign exec_fire = (state_q == ST_EXEC) && out_free;
  assign run_done  = exec_fire && !empty_q;

  assign adm_idx   = TASK_AW'(id_q);
  assign run_idx   = TASK_AW'(fifo_rdata);

  // duplicate, out-of-range id and full level 0 are rejected
  assign adm_ok    = !present_q[adm_idx] && (int'(id_q) < NUM_TASKS)
                   && (sel_cnt < CNT_W'(NUM_TASKS));

  assign task_drop = run_done
                   && ((round.outcome == OUT_FINISHED) || (round.outcome == OUT_BLOCKED));
  assign push_en   = (adm_fire && adm_ok)
                   || (run_done && ((round.outcome == OUT_DEMOTED)
                                    || (round.outcome == OUT_REQUEUED)));

  // queue store: tail write on push, head read on pop
  assign fifo_we    = push_en;
  assign fifo_waddr = fifo_addr(sel_lvl, tail_pos);
  assign fifo_wdata = (state_q == ST_ADM) ? id_q : fifo_rdata;
  assign fifo_raddr = fifo_addr(sel_lvl, sel_head);

  mlfq_ram #(
    .DEPTH  (FIFO_DEPTH),
    .WIDTH  (ID_W),
    .ADDR_W (FIFO_AW)
  ) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (fifo_waddr),
    .wdata_i (fifo_wdata),
    .re_i    (run_pop),
    .raddr_i (fifo_raddr),
    .rdata_o (fifo_rdata)
  );

  // remaining-time table: read once the head id is back, write on commit
  assign rem_re    = (state_q == ST_HEAD);
  assign rem_we    = (adm_fire && adm_ok) || run_done;
  assign rem_waddr = (state_q == ST_ADM) ? adm_idx : run_idx;
  assign rem_wdata = (state_q == ST_ADM) ? burst_q : round.left;

  mlfq_ram #(
    .DEPTH  (NUM_TASKS),
    .WIDTH  (REM_W),
    .ADDR_W (TASK_AW)
  ) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (rem_waddr),
    .wdata_i (rem_wdata),
    .re_i    (rem_re),
    .raddr_i (run_idx),
    .rdata_o (rem_rdata)
  );

  mlfq_round u_round (
    .lvl_i    (lvl_q),
    .rem_i    (rem_rdata),
    .bpoint_i (bp_q),
    .round_o  (round)
  );

  assign elapsed_d = run_done ? elapsed_q + ELAPSED_W'(round.used) : elapsed_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_hs) begin
          if (!s_axis_tuser_i) begin
            state_d = ST_ADM;
          end else if (any_busy) begin
            state_d = ST_HEAD;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_ADM: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_HEAD: state_d = ST_EXEC;
      ST_EXEC: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result word
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_user_d  = out_user_q;
    out_data_d  = out_data_q;
    if (adm_fire) begin
      out_valid_d = 1'b1;
      out_user_d  = adm_ok ? OUT_ADMITTED : OUT_REJECTED;
      out_data_d  = {{OUT_PAD_W{1'b0}}, elapsed_q, (adm_ok ? burst_q : {REM_W{1'b0}}),
                     {USED_W{1'b0}}, {OLVL_W{1'b0}}, id_q};
    end else if (exec_fire) begin
      out_valid_d = 1'b1;
      if (empty_q) begin
        out_user_d = OUT_IDLE;
        out_data_d = {{OUT_PAD_W{1'b0}}, elapsed_q, {REM_W{1'b0}}, {USED_W{1'b0}},
                      {OLVL_W{1'b0}}, {ID_W{1'b0}}};
      end else begin
        out_user_d = round.outcome;
        out_data_d = {{OUT_PAD_W{1'b0}}, elapsed_d, round.left, USED_W'(round.used),
                      OLVL_W'(lvl_q), fifo_rdata};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      elapsed_q   <= '0;
      present_q   <= '0;
      empty_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      elapsed_q   <= elapsed_d;
      if (s_hs) begin
        empty_q <= !any_busy;
      end
      if (adm_fire && adm_ok) begin
        present_q[adm_idx] <= 1'b1;
      end else if (task_drop) begin
        present_q[run_idx] <= 1'b0;
      end
    end
  end

  // level heads and fill counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        heads_q[l]  <= '0;
        counts_q[l] <= '0;
      end
    end else if (run_pop) begin
      heads_q[sel_lvl]  <= head_next;
      counts_q[sel_lvl] <= sel_cnt - 1'b1;
    end else if (push_en) begin
      counts_q[sel_lvl] <= sel_cnt + 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      id_q    <= s_axis_tdata_i[ID_W-1:0];
      burst_q <= s_axis_tdata_i[ID_W +: REM_W];
      bp_q    <= s_axis_tdata_i[ID_W + REM_W +: BP_W];
    end
    if (run_pop) begin
      lvl_q <= enc_lvl;
    end
    out_user_q <= out_user_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== design/mlfq_ram.sv =====
// ----------------------------------------------------------------------------
// mlfq_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mlfq_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mlfq_round.sv =====
// ----------------------------------------------------------------------------
// mlfq_round
// evaluates one quantum: finish, block or quantum expiry, ticks and remainder
// ----------------------------------------------------------------------------
module mlfq_round import mlfq_pkg::*; (
  input  logic [LVL_W-1:0] lvl_i,
  input  logic [REM_W-1:0] rem_i,
  input  logic [BP_W-1:0]  bpoint_i,
  output round_t           round_o
);

  logic [REM_W-1:0] quantum;
  logic [REM_W-1:0] fin_tick;
  logic [REM_W-1:0] bp;
  logic             bp_on;
  logic             finish;
  logic             block;
  logic [REM_W-1:0] sub_amt;
  logic [REM_W-1:0] rem_sub;

  assign quantum  = REM_W'(1) << lvl_i;
  // a zero burst still runs one tick
  assign fin_tick = (rem_i == '0) ? REM_W'(1) : rem_i;
  assign bp       = REM_W'(bpoint_i);
  assign bp_on    = (bpoint_i != '0);

  // finishing wins over blocking on the same tick
  assign finish   = (fin_tick <= quantum) && (!bp_on || (fin_tick <= bp));
  assign block    = !finish && bp_on && (bp <= quantum);

  assign sub_amt  = block ? bp : quantum;
  assign rem_sub  = rem_i - sub_amt;

  always_comb begin
    round_o = '0;
    if (finish) begin
      round_o.outcome = OUT_FINISHED;
      round_o.used    = fin_tick;
      round_o.left    = '0;
    end else if (block) begin
      round_o.outcome = OUT_BLOCKED;
      round_o.used    = bp;
      round_o.left    = rem_sub;
    end else begin
      round_o.outcome = (lvl_i == LVL_W'(NUM_LEVELS - 1)) ? OUT_REQUEUED : OUT_DEMOTED;
      round_o.used    = quantum;
      round_o.left    = rem_sub;
    end
  end

endmodule

// ===== design/mlfq_checker.sv =====
// ----------------------------------------------------------------------------
// mlfq_checker
// port-level checks of the scheduler, attached by bind
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlfq_checker import mlfq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                  s_axis_tuser_i,
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  input  logic [OUTCOME_W-1:0]  m_axis_tuser_i
);

  logic s_hs;
  logic s_stall;
  logic m_stall;

  assign s_hs    = s_axis_tvalid_i && s_axis_tready_i;
  assign s_stall = s_axis_tvalid_i && !s_axis_tready_i;
  assign m_stall = m_axis_tvalid_i && !m_axis_tready_i;

  // one word in flight at a time
  `MLFQ_ASSERT_NXT(a_busy_after_accept, s_hs, !s_axis_tready_i)

  // an offered input word waits unchanged until it is taken
  `MLFQ_ASSERT_NXT(a_in_hold, s_stall,
                   s_axis_tvalid_i && $stable(s_axis_tdata_i) && $stable(s_axis_tuser_i))

  // a stalled result word holds
  `MLFQ_ASSERT_NXT(a_out_hold, m_stall,
                   m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i))

  // an idle round reports no task and no ticks
  `MLFQ_ASSERT_IMP(a_idle_zero, m_axis_tvalid_i && (m_axis_tuser_i == OUT_IDLE),
                   m_axis_tdata_i[25:0] == '0)

  // a finished task ran at least one tick and has nothing left
  `MLFQ_ASSERT_IMP(a_finish_shape, m_axis_tvalid_i && (m_axis_tuser_i == OUT_FINISHED),
                   (m_axis_tdata_i[25:10] == '0) && (m_axis_tdata_i[9:6] != '0))

endmodule

bind multilevel_feedback_queue_scheduler mlfq_checker u_mlfq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);

// ===== tb/tb_multilevel_feedback_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// tb_multilevel_feedback_queue_scheduler
// self-checking bench: admits and scheduling rounds go in over the input
// stream, a software copy of the level queues predicts every result word,
// and each word taken from the output stream is compared field by field
// ----------------------------------------------------------------------------
module tb_multilevel_feedback_queue_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import mlfq_pkg::*;

  localparam int unsigned RANDOM_WORDS = 680;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_LIMIT  = 2000;
  localparam int unsigned SETTLE       = 16;

  // one predicted result word
  typedef struct {
    outcome_e               outcome;
    logic [ID_W-1:0]        id;
    logic [OLVL_W-1:0]      lvl;
    logic [USED_W-1:0]      used;
    logic [REM_W-1:0]       left;
    logic [ELAPSED_W-1:0]   elapsed;
  } sched_word_t;

  // shadow of the scheduler plus the list of words still owed by the block
  class mlfq_scoreboard;
    logic [ID_W-1:0]      ready_q [NUM_LEVELS][$];
    logic [REM_W-1:0]     ticks_owed [NUM_TASKS];
    bit                   queued [NUM_TASKS];
    logic [ELAPSED_W-1:0] tick_count;
    sched_word_t          awaited [$];
    int unsigned          errors;
    int unsigned          words_seen;
    int unsigned          outcome_seen [8];

    function new();
      tick_count = '0;
      errors     = 0;
      words_seen = 0;
      foreach (queued[i]) begin
        queued[i]     = 1'b0;
        ticks_owed[i] = '0;
      end
      foreach (outcome_seen[i]) outcome_seen[i] = 0;
    endfunction

    // work out the result of one accepted input word
    function void predict_outcome(bit is_run, logic [ID_W-1:0] id,
                                  logic [REM_W-1:0] burst, logic [BP_W-1:0] bp);
      sched_word_t  w;
      int           lvl;
      logic [REM_W-1:0] rem;
      int unsigned  quantum;
      bit           settled;
      w.outcome = OUT_IDLE;
      w.id      = '0;
      w.lvl     = '0;
      w.used    = '0;
      w.left    = '0;
      if (!is_run) begin
        w.id = id;
        if (queued[id]) begin
          w.outcome = OUT_REJECTED;
        end else begin
          queued[id]     = 1'b1;
          ticks_owed[id] = burst;
          ready_q[0].push_back(id);
          w.outcome      = OUT_ADMITTED;
          w.left         = burst;
        end
      end else begin
        lvl = -1;
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
          if (ready_q[l].size() != 0) lvl = l;
        if (lvl >= 0) begin
          w.id      = ready_q[lvl].pop_front();
          w.lvl     = OLVL_W'(lvl);
          rem       = ticks_owed[w.id];
          quantum   = 1 << lvl;
          settled   = 1'b0;
          w.outcome = (lvl < NUM_LEVELS - 1) ? OUT_DEMOTED : OUT_REQUEUED;
          for (int unsigned t = 1; t <= quantum && !settled; t++) begin
            w.used = USED_W'(t);
            if (rem != 0) rem--;
            tick_count++;
            // finishing wins over blocking on the same tick
            if (rem == 0) begin
              w.outcome = OUT_FINISHED;
              settled   = 1'b1;
            end else if (bp != 0 && t == bp) begin
              w.outcome = OUT_BLOCKED;
              settled   = 1'b1;
            end
          end
          ticks_owed[w.id] = rem;
          w.left           = rem;
          case (w.outcome)
            OUT_FINISHED, OUT_BLOCKED: queued[w.id] = 1'b0;
            OUT_DEMOTED:               ready_q[lvl + 1].push_back(w.id);
            default:                   ready_q[lvl].push_back(w.id);
          endcase
        end
      end
      w.elapsed = tick_count;
      awaited.push_back(w);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      end
    endfunction

    // compare one taken result word with the oldest prediction
    function void check_outcome(logic [OUTCOME_W-1:0] code, logic [OUT_DATA_W-1:0] data);
      sched_word_t w;
      words_seen++;
      outcome_seen[code]++;
      if (awaited.size() == 0) begin
        errors++;
        $error("result word with nothing awaited: outcome %0d data %0h", code, data);
        return;
      end
      w = awaited.pop_front();
      compare_field("outcome",      64'(w.outcome), 64'(code));
      compare_field("served_id",    64'(w.id),      64'(data[3:0]));
      compare_field("served_level", 64'(w.lvl),     64'(data[5:4]));
      compare_field("ticks_used",   64'(w.used),    64'(data[9:6]));
      compare_field("ticks_left",   64'(w.left),    64'(data[25:10]));
      compare_field("elapsed",      64'(w.elapsed), 64'(data[57:26]));
      compare_field("tdata padding", 64'(0),        64'(data[63:58]));
    endfunction
  endclass

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  // task_id [3:0], burst_length [19:4], block_point [27:20], zero [31:28]
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  // action [0]
  logic                  s_axis_tuser_i  = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // served_id [3:0], served_level [5:4], ticks_used [9:6], ticks_left [25:10],
  // elapsed [57:26], zero [63:58]
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  // outcome [2:0]
  logic [OUTCOME_W-1:0]  m_axis_tuser_o;

  // asks the result side for one long hold-off
  bit hold_request = 1'b0;

  mlfq_scoreboard tracker = new();

  multilevel_feedback_queue_scheduler uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // present one word and hold it until the block takes it
  task automatic offer_word(input bit is_run, input logic [ID_W-1:0] id,
                            input logic [REM_W-1:0] burst, input logic [BP_W-1:0] bp);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= is_run;
    s_axis_tdata_i  <= {{IN_PAD_W{1'b0}}, bp, burst, id};
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.predict_outcome(is_run, id, burst, bp);
  endtask

  // admit with a random don't-care block point
  task automatic admit_task(input logic [ID_W-1:0] id, input logic [REM_W-1:0] burst);
    offer_word(1'b0, id, burst, BP_W'($urandom));
  endtask

  // scheduling round with random don't-care id and burst
  task automatic run_round(input logic [BP_W-1:0] bp);
    offer_word(1'b1, ID_W'($urandom), REM_W'($urandom), bp);
  endtask

  // drop valid and sit out some cycles
  task automatic idle_sender(input int unsigned cycles);
    s_axis_tvalid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // result side: checks every taken word, stalls on its own pattern and
  // honors a requested long hold-off counted here
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned style;
    int unsigned style_left;
    int unsigned beat;
    hold_left  = 0;
    style      = 0;
    style_left = 0;
    beat       = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        tracker.check_outcome(m_axis_tuser_o, m_axis_tdata_o);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      beat++;
      // switch between always ready, random stalls and a fixed duty pattern
      if (style_left == 0) begin
        style      = $urandom_range(0, 2);
        style_left = $urandom_range(20, 200);
      end else begin
        style_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        case (style)
          0:       m_axis_tready_i <= 1'b1;
          1:       m_axis_tready_i <= ($urandom_range(0, 99) >= 35);
          default: m_axis_tready_i <= ((beat % 7) >= 3);
        endcase
      end
    end
  end

  // word source and end of run
  initial begin : word_source
    int unsigned burst_left;
    int unsigned pick;
    int unsigned guard;
    logic [REM_W-1:0] burst;
    logic [BP_W-1:0]  bp;
    burst_left = 0;
    guard      = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle round on an empty scheduler
    run_round(8'd0);
    // zero burst and the widest burst at the id extremes
    admit_task(4'd0, 16'd0);
    admit_task(4'd15, 16'hFFFF);
    // duplicate admit is turned away
    admit_task(4'd0, 16'h1234);
    // zero burst runs one tick and finishes
    run_round(8'd0);
    // wide task is demoted from level 0; later rounds walk it down through every level
    run_round(8'd0);
    // last tick both finishes and hits the blocking point: finished
    admit_task(4'd5, 16'd1);
    run_round(8'd1);
    // blocking point at the end of the level 0 quantum: blocked
    admit_task(4'd6, 16'd10);
    run_round(8'd1);
    run_round(8'd255);
    run_round(8'd128);
    // last level keeps the task, then blocks at the 8-tick quantum end
    run_round(8'd0);
    run_round(8'd8);
    // everything dropped: idle again
    run_round(8'd0);
    // dropped ids can come back
    admit_task(4'd15, 16'd3);
    admit_task(4'd10, 16'hAAAA);
    admit_task(4'd3, 16'h5555);
    run_round(8'hFF);
    run_round(8'h80);
    run_round(8'd2);
    run_round(8'h7F);

    // random traffic in bursts with random gaps
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      // long receiver hold-off while words keep coming
      if (n == RANDOM_WORDS / 3) hold_request = 1'b1;
      // sender stops until the block has answered everything
      if (n == (2 * RANDOM_WORDS) / 3) begin
        idle_sender(1);
        while (tracker.awaited.size() != 0) @(posedge clk_i);
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
      end
      burst_left--;
      if ($urandom_range(0, 99) < 45) begin
        pick = $urandom_range(0, 99);
        if (pick < 10)      burst = '0;
        else if (pick < 70) burst = REM_W'($urandom_range(1, 12));
        else if (pick < 92) burst = REM_W'($urandom_range(13, 60));
        else                burst = REM_W'($urandom);
        admit_task(ID_W'($urandom_range(0, NUM_TASKS - 1)), burst);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      bp = '0;
        else if (pick < 85) bp = BP_W'($urandom_range(1, 8));
        else                bp = BP_W'($urandom_range(0, 255));
        run_round(bp);
      end
    end
    idle_sender(1);

    // collect what is still owed, then watch for stray words
    while (tracker.awaited.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE) @(posedge clk_i);
    if (tracker.awaited.size() != 0) begin
      tracker.errors++;
      $error("%0d result words never arrived", tracker.awaited.size());
    end

    $display("checked %0d result words after %0d cycles", tracker.words_seen,
             $time / 12ns);
    $display("admitted %0d, rejected %0d, idle %0d, finished %0d, blocked %0d, demoted %0d, requeued %0d",
             tracker.outcome_seen[OUT_ADMITTED], tracker.outcome_seen[OUT_REJECTED],
             tracker.outcome_seen[OUT_IDLE], tracker.outcome_seen[OUT_FINISHED],
             tracker.outcome_seen[OUT_BLOCKED], tracker.outcome_seen[OUT_DEMOTED],
             tracker.outcome_seen[OUT_REQUEUED]);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/mlfq_pkg.sv
design/mlfq_ram.sv
design/mlfq_round.sv
design/multilevel_feedback_queue_scheduler.sv
design/mlfq_checker.sv
tb/tb_multilevel_feedback_queue_scheduler.sv
